/* hw/rtl/pmp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pmp_pkg
// Shared constants and stage types of the paraboloid mirror projection.
// ----------------------------------------------------------------------------
package pmp_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int COORD_W     = 32;
   localparam int NUM_LANES   = 3;
   localparam int DATA_W      = COORD_W * NUM_LANES;
   localparam int PARAM_W     = 31;
   localparam int SQ_W        = 2 * COORD_W;
   localparam int ROOT_W      = COORD_W;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STAGES = ROOT_W;
   localparam int DEN_W       = COORD_W + 1;
   localparam int PROD_W      = PARAM_W + COORD_W;
   localparam int NUM_W       = SQ_W;
   localparam int QUOT_W      = DEN_W;
   localparam int DIV_STAGES  = QUOT_W;

   localparam logic [PARAM_W-1:0] PARAM_RESET = PARAM_W'(1 << FRAC_BITS);
   localparam logic [COORD_W-1:0] SAT_POS     = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic [COORD_W-1:0] SAT_NEG     = {1'b1, {(COORD_W-1){1'b0}}};

   // Magnitudes and signs of one point, lane 0 is x.
   typedef struct packed {
      logic [NUM_LANES-1:0][COORD_W-1:0] mag;
      logic [NUM_LANES-1:0]              neg;
   } side_type;

   // One coordinate inside the divider.
   typedef struct packed {
      logic [DEN_W-1:0]  rem;
      logic [DEN_W-1:0]  nlo;
      logic [QUOT_W-1:0] quot;
      logic              ovf;
      logic              neg;
   } lane_type;

   typedef lane_type [NUM_LANES-1:0] lanes_type;

endpackage

/* hw/rtl/paraboloid_mirror_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// paraboloid_mirror_projection
// Maps a 3D point onto a paraboloid mirror: h * (X, Y, Z) / (|P| + Z).
// ----------------------------------------------------------------------------
// Usage: a point enters on the req_ stream as one word holding X, Y and Z in
// signed Q16.16. The result word leaves on the rsp_ stream with the three
// mirror coordinates, saturated to the 32-bit range, and a flag in rsp_tuser
// that is set when the denominator is positive. When the flag is clear the
// coordinates are zero.
// The mirror parameter h is written through csr_write_en / csr_write_data
// while no word is in flight; reset loads 1.0.
// From acceptance to rsp_tvalid the word passes one input stage, one
// multiply stage for the squares, one sum stage, 32 square-root stages (one
// root bit each), three stages that form the denominator, the products and
// the overflow check, 33 divider stages (one quotient bit each, all three
// coordinates side by side) and the output register.
// Throughput is one word per cycle unless stalled. The whole pipeline
// advances together whenever the output register is empty or being taken,
// so a stall on the rsp_ side freezes every stage and drops req_tready.
// Reset (synchronous) clears all stage valid bits and the output valid bit;
// the data registers keep their contents.
// ----------------------------------------------------------------------------
module paraboloid_mirror_projection (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [pmp_pkg::PARAM_W-1:0]   csr_write_data,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // point_x [31:0], point_y [63:32], point_z [95:64]
   input  logic [pmp_pkg::DATA_W-1:0]    req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // mirror_x [31:0], mirror_y [63:32], mirror_z [95:64]
   output logic [pmp_pkg::DATA_W-1:0]    rsp_tdata,
   // valid_res [0]
   output logic                          rsp_tuser
);
   import pmp_pkg::*;

   logic                 adv;
   logic [PARAM_W-1:0]   param_ff;

   side_type             p0_side_ff, p0_side_in;
   logic                 p0_valid_ff;
   side_type             p1_side_ff;
   logic [NUM_LANES-1:0][SQ_W-1:0] p1_sq_ff;
   logic                 p1_valid_ff;
   side_type             p2_side_ff;
   logic [SQ_W-1:0]      p2_sum_ff;
   logic                 p2_valid_ff;

   logic [REM_W-1:0]     sq_rem_ff   [SQRT_STAGES];
   logic [ROOT_W-1:0]    sq_root_ff  [SQRT_STAGES];
   logic [SQ_W-1:0]      sq_rad_ff   [SQRT_STAGES];
   side_type             sq_side_ff  [SQRT_STAGES];
   logic                 sq_valid_ff [SQRT_STAGES];

   // Denominator and products.
   logic [DEN_W-1:0]     p3_den_ff, p3_den_in;
   logic                 p3_dpos_ff, p3_dpos_in;
   logic [NUM_LANES-1:0][PROD_W-1:0] p3_prod_ff;
   logic [NUM_LANES-1:0] p3_neg_ff;
   logic                 p3_valid_ff;
   logic [DEN_W+1:0]     den_full;
   logic [DEN_W+1:0]     z_full;
   side_type             sq_last;

   // Rounded numerators.
   logic [DEN_W-1:0]     p4_den_ff;
   logic                 p4_dpos_ff;
   logic [NUM_LANES-1:0][NUM_W-1:0] p4_num_ff;
   logic [NUM_LANES-1:0] p4_neg_ff;
   logic                 p4_valid_ff;

   // Overflow check and divider setup.
   logic [DEN_W-1:0]     p5_den_ff;
   logic                 p5_dpos_ff;
   lanes_type            p5_lane_ff, p5_lane_in;
   logic                 p5_valid_ff;

   logic [DEN_W-1:0]     dv_den_ff   [DIV_STAGES];
   logic                 dv_dpos_ff  [DIV_STAGES];
   lanes_type            dv_lane_ff  [DIV_STAGES];
   logic                 dv_valid_ff [DIV_STAGES];

   logic [DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                 rsp_user_ff;
   logic                 rsp_valid_ff;

   // The pipeline moves as one; it holds only while a result waits untaken.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         param_ff <= PARAM_RESET;
      end else if (csr_write_en) begin
         param_ff <= csr_write_data;
      end
   end

   // Input stage: split the word into magnitudes and signs.
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         p0_side_in.neg[i] = req_tdata[i*COORD_W + COORD_W - 1];
         p0_side_in.mag[i] = p0_side_in.neg[i] ? (~req_tdata[i*COORD_W +: COORD_W] + 1'b1)
                                               : req_tdata[i*COORD_W +: COORD_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p0_valid_ff <= 1'b0;
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else if (adv) begin
         p0_valid_ff <= req_tvalid;
         p1_valid_ff <= p0_valid_ff;
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p0_side_ff <= p0_side_in;
         p1_side_ff <= p0_side_ff;
         for (int i = 0; i < NUM_LANES; i++) begin
            p1_sq_ff[i] <= p0_side_ff.mag[i] * p0_side_ff.mag[i];
         end
         p2_side_ff <= p1_side_ff;
         p2_sum_ff  <= p1_sq_ff[0] + p1_sq_ff[1] + p1_sq_ff[2];
      end
   end

   // Square root, one result bit per stage.
   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
      logic [REM_W-1:0]  rem_prev;
      logic [ROOT_W-1:0] root_prev;
      logic [SQ_W-1:0]   rad_prev;
      side_type          side_prev;
      logic              valid_prev;
      logic [REM_W+1:0]  rem_shift;
      logic [REM_W+1:0]  trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev   = '0;
         assign root_prev  = '0;
         assign rad_prev   = p2_sum_ff;
         assign side_prev  = p2_side_ff;
         assign valid_prev = p2_valid_ff;
      end else begin : g_next
         assign rem_prev   = sq_rem_ff[k-1];
         assign root_prev  = sq_root_ff[k-1];
         assign rad_prev   = sq_rad_ff[k-1];
         assign side_prev  = sq_side_ff[k-1];
         assign valid_prev = sq_valid_ff[k-1];
      end

      assign rem_shift = {rem_prev, rad_prev[SQ_W-1 -: 2]};
      assign trial     = {2'b00, root_prev, 2'b01};
      assign ge        = rem_shift >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_valid_ff[k] <= 1'b0;
         end else if (adv) begin
            sq_valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_rem_ff[k]  <= ge ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
            sq_root_ff[k] <= {root_prev[ROOT_W-2:0], ge};
            sq_rad_ff[k]  <= {rad_prev[SQ_W-3:0], 2'b00};
            sq_side_ff[k] <= side_prev;
         end
      end
   end

   // Denominator r + Z, with two guard bits for the sign.
   assign sq_last   = sq_side_ff[SQRT_STAGES-1];
   assign z_full    = sq_last.neg[2] ? (~{3'b000, sq_last.mag[2]} + 1'b1)
                                     : {3'b000, sq_last.mag[2]};
   assign den_full  = {2'b00, sq_root_ff[SQRT_STAGES-1]} + z_full;
   assign p3_dpos_in = !den_full[DEN_W+1] && (den_full != '0);
   assign p3_den_in  = den_full[DEN_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         p3_valid_ff <= 1'b0;
         p4_valid_ff <= 1'b0;
         p5_valid_ff <= 1'b0;
      end else if (adv) begin
         p3_valid_ff <= sq_valid_ff[SQRT_STAGES-1];
         p4_valid_ff <= p3_valid_ff;
         p5_valid_ff <= p4_valid_ff;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         p5_lane_in[i].ovf  = {2'b00, p4_num_ff[i]} >= {p4_den_ff, {QUOT_W{1'b0}}};
         p5_lane_in[i].rem  = DEN_W'(p4_num_ff[i][NUM_W-1:QUOT_W]);
         p5_lane_in[i].nlo  = p4_num_ff[i][QUOT_W-1:0];
         p5_lane_in[i].quot = '0;
         p5_lane_in[i].neg  = p4_neg_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p3_den_ff  <= p3_den_in;
         p3_dpos_ff <= p3_dpos_in;
         p3_neg_ff  <= sq_last.neg;
         for (int i = 0; i < NUM_LANES; i++) begin
            p3_prod_ff[i] <= param_ff * sq_last.mag[i];
         end
         p4_den_ff  <= p3_den_ff;
         p4_dpos_ff <= p3_dpos_ff;
         p4_neg_ff  <= p3_neg_ff;
         for (int i = 0; i < NUM_LANES; i++) begin
            p4_num_ff[i] <= {1'b0, p3_prod_ff[i]} + NUM_W'(p3_den_ff >> 1);
         end
         p5_den_ff  <= p4_den_ff;
         p5_dpos_ff <= p4_dpos_ff;
         p5_lane_ff <= p5_lane_in;
      end
   end

   // Restoring division, one quotient bit per stage for all three lanes.
   for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      logic [DEN_W-1:0] den_prev;
      logic             dpos_prev;
      lanes_type        lane_prev;
      logic             valid_prev;
      lanes_type        lane_next;

      if (j == 0) begin : g_first
         assign den_prev   = p5_den_ff;
         assign dpos_prev  = p5_dpos_ff;
         assign lane_prev  = p5_lane_ff;
         assign valid_prev = p5_valid_ff;
      end else begin : g_next
         assign den_prev   = dv_den_ff[j-1];
         assign dpos_prev  = dv_dpos_ff[j-1];
         assign lane_prev  = dv_lane_ff[j-1];
         assign valid_prev = dv_valid_ff[j-1];
      end

      always_comb begin
         logic [DEN_W:0] rem_shift;
         logic           ge;
         for (int i = 0; i < NUM_LANES; i++) begin
            rem_shift         = {lane_prev[i].rem, lane_prev[i].nlo[DEN_W-1]};
            ge                = rem_shift >= {1'b0, den_prev};
            lane_next[i].rem  = ge ? DEN_W'(rem_shift - {1'b0, den_prev})
                                   : DEN_W'(rem_shift);
            lane_next[i].nlo  = {lane_prev[i].nlo[DEN_W-2:0], 1'b0};
            lane_next[i].quot = {lane_prev[i].quot[QUOT_W-2:0], ge};
            lane_next[i].ovf  = lane_prev[i].ovf;
            lane_next[i].neg  = lane_prev[i].neg;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_valid_ff[j] <= 1'b0;
         end else if (adv) begin
            dv_valid_ff[j] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dv_den_ff[j]  <= den_prev;
            dv_dpos_ff[j] <= dpos_prev;
            dv_lane_ff[j] <= lane_next;
         end
      end
   end

   // Sign, saturation and the undefined case.
   always_comb begin
      lane_type lane;
      for (int i = 0; i < NUM_LANES; i++) begin
         lane = dv_lane_ff[DIV_STAGES-1][i];
         if (!dv_dpos_ff[DIV_STAGES-1]) begin
            rsp_data_in[i*COORD_W +: COORD_W] = '0;
         end else if (lane.neg) begin
            if (lane.ovf || lane.quot > QUOT_W'(SAT_NEG)) begin
               rsp_data_in[i*COORD_W +: COORD_W] = SAT_NEG;
            end else begin
               rsp_data_in[i*COORD_W +: COORD_W] = ~lane.quot[COORD_W-1:0] + 1'b1;
            end
         end else begin
            if (lane.ovf || lane.quot > QUOT_W'(SAT_POS)) begin
               rsp_data_in[i*COORD_W +: COORD_W] = SAT_POS;
            end else begin
               rsp_data_in[i*COORD_W +: COORD_W] = lane.quot[COORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid_ff[DIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= dv_dpos_ff[DIV_STAGES-1];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef NO_ASSERTIONS
   // An undefined projection must come out as all-zero coordinates.
   a_zero_when_undefined: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("undefined projection with nonzero coordinates");

   // Reset empties the output register.
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result word present after reset");

   // A word waiting at the output blocks new input.
   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("input accepted while the pipeline is frozen");
`endif

endmodule
